### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 6502 core.
// Checks are compiled in unless ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/c6502_pkg.sv
// ----------------------------------------------------------------------------
// c6502_pkg
// Types, constants and the opcode decoder of the 6502 core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package c6502_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

	localparam int FB_N = 7;
	localparam int FB_V = 6;
	localparam int FB_U = 5;
	localparam int FB_B = 4;
	localparam int FB_D = 3;
	localparam int FB_I = 2;
	localparam int FB_Z = 1;
	localparam int FB_C = 0;

	localparam logic [7:0]  SP_RESET    = 8'hFD;
	localparam logic [7:0]  FLAGS_RESET = 8'h24;
	localparam logic [7:0]  STACK_PAGE  = 8'h01;
	localparam logic [15:0] IRQ_VEC_LO  = 16'hFFFE;
	localparam logic [15:0] IRQ_VEC_HI  = 16'hFFFF;
	localparam logic [7:0]  OPC_RTS     = 8'h60;

	localparam logic [2:0] KIND_STEP  = 3'd0;
	localparam logic [2:0] KIND_IRQ   = 3'd1;
	localparam logic [2:0] KIND_RESET = 3'd2;
	localparam logic [2:0] KIND_WRITE = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	typedef enum logic [3:0] {
		OP_PASS, OP_OR, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_LD, OP_CMP,
		OP_BIT, OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_INC, OP_DEC
	} alu_op_t;

	typedef enum logic [3:0] {
		AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY, AM_INDX, AM_INDY
	} am_t;

	typedef enum logic [3:0] {
		CL_BAD, CL_BRK, CL_BRANCH, CL_IMPL, CL_PUSH, CL_PULL, CL_JMP, CL_JMPI,
		CL_JSR, CL_RTS, CL_RTI, CL_READ, CL_STORE, CL_RMW
	} cls_t;

	typedef enum logic [2:0] {R_A, R_X, R_Y, R_S, R_P} rsel_t;

	typedef enum logic [2:0] {D_NONE, D_A, D_X, D_Y, D_S, D_P, D_MEM} dst_t;

	typedef struct packed {
		cls_t       cls;
		am_t        mode;
		alu_op_t    aop;
		rsel_t      rsel;
		dst_t       dst;
		logic [2:0] cyc;
		logic [7:0] fmask;
		logic [7:0] fval;
	} dec_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_FETCH, S_DEC, S_DISP, S_A2, S_A3, S_I1, S_I2, S_OPER,
		S_RD, S_JI1, S_JI2, S_JS2, S_BR, S_PL, S_P1, S_P2, S_P3, S_IRQ1, S_IRQ2,
		S_IRQ3, S_IRQ4, S_IRQ5, S_IRQ6, S_RESET, S_MWR, S_MRD, S_MRD2, S_DONE
	} state_t;

	localparam am_t ALU_MODE [0:7] = '{AM_INDX, AM_ZP, AM_IMM, AM_ABS,
		AM_INDY, AM_ZPX, AM_ABSY, AM_ABSX};
	localparam logic [2:0] ALU_CYC [0:7] = '{3'd6, 3'd3, 3'd2, 3'd4,
		3'd5, 3'd4, 3'd4, 3'd4};
	localparam logic [2:0] STA_CYC [0:7] = '{3'd6, 3'd3, 3'd0, 3'd4,
		3'd6, 3'd4, 3'd5, 3'd5};
	localparam am_t GRP_MODE [0:7] = '{AM_IMM, AM_ZP, AM_IMM, AM_ABS,
		AM_IMM, AM_ZPX, AM_IMM, AM_ABSX};
	localparam logic [2:0] LD_CYC [0:7] = '{3'd2, 3'd3, 3'd0, 3'd4,
		3'd0, 3'd4, 3'd0, 3'd4};
	localparam logic [2:0] RMW_CYC [0:7] = '{3'd0, 3'd5, 3'd2, 3'd6,
		3'd0, 3'd6, 3'd0, 3'd7};

	function automatic alu_op_t shift_op(input logic [2:0] aaa);
		alu_op_t r;
		case (aaa)
			3'd0: r = OP_ASL;
			3'd1: r = OP_ROL;
			3'd2: r = OP_LSR;
			default: r = OP_ROR;
		endcase
		return r;
	endfunction

	function automatic dec_t impl(input rsel_t rs, input alu_op_t op, input dst_t dt);
		dec_t d;
		d = '{cls: CL_IMPL, mode: AM_IMM, aop: op, rsel: rs, dst: dt, cyc: 3'd2,
			fmask: 8'h00, fval: 8'h00};
		return d;
	endfunction

	function automatic dec_t flag_op(input int bitpos, input logic val);
		dec_t d;
		d = impl(R_A, OP_PASS, D_NONE);
		d.fmask = 8'(1 << bitpos);
		d.fval = val ? d.fmask : 8'h00;
		return d;
	endfunction

	function automatic dec_t decode(input logic [7:0] op);
		dec_t d;
		logic [2:0] aaa;
		logic [2:0] bbb;
		logic [1:0] cc;
		logic [7:0] vmask;
		aaa = op[7:5];
		bbb = op[4:2];
		cc = op[1:0];
		vmask = 8'h00;
		d = '{cls: CL_BAD, mode: AM_IMM, aop: OP_PASS, rsel: R_A, dst: D_NONE,
			cyc: 3'd0, fmask: 8'h00, fval: 8'h00};
		if (op[4:0] == 5'h10) begin
			d.cls = CL_BRANCH;
			d.cyc = 3'd2;
		end else begin
			case (op)
				8'h00: begin
					d.cls = CL_BRK;
					d.cyc = 3'd7;
				end
				8'hEA: d = impl(R_A, OP_PASS, D_NONE);
				8'h18: d = flag_op(FB_C, 1'b0);
				8'h38: d = flag_op(FB_C, 1'b1);
				8'h58: d = flag_op(FB_I, 1'b0);
				8'h78: d = flag_op(FB_I, 1'b1);
				8'hB8: d = flag_op(FB_V, 1'b0);
				8'hD8: d = flag_op(FB_D, 1'b0);
				8'hF8: d = flag_op(FB_D, 1'b1);
				8'hAA: d = impl(R_A, OP_LD, D_X);
				8'h8A: d = impl(R_X, OP_LD, D_A);
				8'hA8: d = impl(R_A, OP_LD, D_Y);
				8'h98: d = impl(R_Y, OP_LD, D_A);
				8'h9A: d = impl(R_X, OP_PASS, D_S);
				8'hBA: d = impl(R_S, OP_LD, D_X);
				8'hE8: d = impl(R_X, OP_INC, D_X);
				8'hC8: d = impl(R_Y, OP_INC, D_Y);
				8'hCA: d = impl(R_X, OP_DEC, D_X);
				8'h88: d = impl(R_Y, OP_DEC, D_Y);
				8'h48: begin
					d.cls = CL_PUSH;
					d.rsel = R_A;
					d.cyc = 3'd3;
				end
				8'h08: begin
					d.cls = CL_PUSH;
					d.rsel = R_P;
					d.cyc = 3'd3;
				end
				8'h68: begin
					d.cls = CL_PULL;
					d.aop = OP_LD;
					d.dst = D_A;
					d.cyc = 3'd4;
				end
				8'h28: begin
					d.cls = CL_PULL;
					d.dst = D_P;
					d.cyc = 3'd4;
				end
				8'h4C: begin
					d.cls = CL_JMP;
					d.mode = AM_ABS;
					d.cyc = 3'd3;
				end
				8'h6C: begin
					d.cls = CL_JMPI;
					d.mode = AM_ABS;
					d.cyc = 3'd5;
				end
				8'h20: begin
					d.cls = CL_JSR;
					d.mode = AM_ABS;
					d.cyc = 3'd6;
				end
				8'h60: begin
					d.cls = CL_RTS;
					d.cyc = 3'd6;
				end
				8'h40: begin
					d.cls = CL_RTI;
					d.cyc = 3'd6;
				end
				default: begin
					if (cc == 2'd1) begin
						if (!(aaa == 3'd4 && bbb == 3'd2)) begin
							d.mode = ALU_MODE[bbb];
							if (aaa == 3'd4) begin
								d.cls = CL_STORE;
								d.cyc = STA_CYC[bbb];
							end else begin
								d.cls = CL_READ;
								d.cyc = ALU_CYC[bbb];
								d.dst = D_A;
								case (aaa)
									3'd0: d.aop = OP_OR;
									3'd1: d.aop = OP_AND;
									3'd2: d.aop = OP_EOR;
									3'd3: d.aop = OP_ADC;
									3'd5: d.aop = OP_LD;
									3'd6: begin
										d.aop = OP_CMP;
										d.dst = D_NONE;
									end
									default: d.aop = OP_SBC;
								endcase
							end
						end
					end else if (cc != 2'd3) begin
						if (cc == 2'd0) begin
							case (aaa)
								3'd1: vmask = 8'h0A;
								3'd4: vmask = 8'h2A;
								3'd5: vmask = 8'hAB;
								3'd6, 3'd7: vmask = 8'h0B;
								default: vmask = 8'h00;
							endcase
						end else begin
							case (aaa)
								3'd4: vmask = 8'h2A;
								3'd5: vmask = 8'hAB;
								3'd6, 3'd7: vmask = 8'hAA;
								default: vmask = 8'hAE;
							endcase
						end
						if (vmask[bbb]) begin
							d.mode = GRP_MODE[bbb];
							if (cc == 2'd2 && (aaa == 3'd4 || aaa == 3'd5)) begin
								if (d.mode == AM_ZPX) d.mode = AM_ZPY;
								if (d.mode == AM_ABSX) d.mode = AM_ABSY;
							end
							d.cyc = (cc == 2'd2 && aaa != 3'd4 && aaa != 3'd5) ?
								RMW_CYC[bbb] : LD_CYC[bbb];
							if (cc == 2'd2 && bbb == 3'd2) begin
								// Accumulator form of the shifts and rotates.
								d.cls = CL_IMPL;
								d.aop = shift_op(aaa);
								d.rsel = R_A;
								d.dst = D_A;
							end else if (cc == 2'd0) begin
								case (aaa)
									3'd1: begin
										d.cls = CL_READ;
										d.aop = OP_BIT;
									end
									3'd4: begin
										d.cls = CL_STORE;
										d.rsel = R_Y;
									end
									3'd5: begin
										d.cls = CL_READ;
										d.aop = OP_LD;
										d.dst = D_Y;
									end
									3'd6: begin
										d.cls = CL_READ;
										d.aop = OP_CMP;
										d.rsel = R_Y;
									end
									default: begin
										d.cls = CL_READ;
										d.aop = OP_CMP;
										d.rsel = R_X;
									end
								endcase
							end else begin
								case (aaa)
									3'd4: begin
										d.cls = CL_STORE;
										d.rsel = R_X;
									end
									3'd5: begin
										d.cls = CL_READ;
										d.aop = OP_LD;
										d.dst = D_X;
									end
									3'd6: begin
										d.cls = CL_RMW;
										d.aop = OP_DEC;
										d.dst = D_MEM;
									end
									3'd7: begin
										d.cls = CL_RMW;
										d.aop = OP_INC;
										d.dst = D_MEM;
									end
									default: begin
										d.cls = CL_RMW;
										d.aop = shift_op(aaa);
										d.dst = D_MEM;
									end
								endcase
							end
						end
					end
				end
			endcase
		end
		return d;
	endfunction

endpackage
`default_nettype wire

### rtl/cpu_8bit_6502_core_top.sv
// ----------------------------------------------------------------------------
// cpu_8bit_6502_core_top
// A step makes one memory access per cycle through the single memory port. One
// word is in flight at a time; the next is accepted in the cycle after the result
// is loaded into the output register, which waits there while the output stalls.
// After reset the memory is cleared, one byte a cycle, over all 2^MEM_ADDR_BITS
// addresses (65536), and no word is accepted until that pass ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpu_8bit_6502_core_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       acc_value,
	output logic [7:0]       x_value,
	output logic [7:0]       y_value,
	output logic [7:0]       stack_pointer,
	output logic [15:0]      program_counter,
	output logic [7:0]       status_flags,
	output logic [31:0]      cycle_count,
	output logic             is_halted,
	output logic [7:0]       read_value
);

	localparam int AW = c6502_pkg::MEM_ADDR_BITS;

	c6502_pkg::state_t state_q, state_d;
	c6502_pkg::dec_t   dec;

	logic [AW-1:0] clr_q;
	logic [2:0]    kind_q;
	logic [15:0]   addr_q;
	logic [7:0]    wdata_q;
	logic [7:0]    op_q, tmp_q, rv_q;
	logic [15:0]   ea_q, pc_q;
	logic [7:0]    a_q, x_q, y_q, s_q, p_q;
	logic [31:0]   cyc_q;
	logic          halt_q;
	logic          out_valid_q;

	logic [15:0] mem_a16;
	logic        mem_we;
	logic [7:0]  mem_wd;
	logic [7:0]  rdata;
	logic [7:0]  alu_a, alu_b, alu_res, alu_flags;
	logic [7:0]  idx;
	logic [7:0]  zp;
	logic [15:0] ea_abs;
	logic [15:0] pcm1;
	logic        taken;
	logic        in_acc, out_load;

	function automatic logic [7:0] reg_sel(input c6502_pkg::rsel_t r, input logic [7:0] a,
		input logic [7:0] x, input logic [7:0] y, input logic [7:0] s, input logic [7:0] p);
		logic [7:0] v;
		case (r)
			c6502_pkg::R_A: v = a;
			c6502_pkg::R_X: v = x;
			c6502_pkg::R_Y: v = y;
			c6502_pkg::R_S: v = s;
			default: v = p | 8'h30;
		endcase
		return v;
	endfunction

	assign dec = c6502_pkg::decode(op_q);
	assign in_acc = in_valid && !in_stall;
	assign out_load = (state_q == c6502_pkg::S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign pcm1 = pc_q - 16'd1;

	always_comb begin
		case (dec.mode)
			c6502_pkg::AM_ABSX: idx = x_q;
			c6502_pkg::AM_ABSY, c6502_pkg::AM_INDY: idx = y_q;
			default: idx = 8'h00;
		endcase
		case (dec.mode)
			c6502_pkg::AM_ZPX, c6502_pkg::AM_INDX: zp = rdata + x_q;
			c6502_pkg::AM_ZPY: zp = rdata + y_q;
			default: zp = rdata;
		endcase
		ea_abs = {rdata, tmp_q} + {8'h00, idx};
		case (op_q[7:6])
			2'd0: taken = p_q[c6502_pkg::FB_N] == op_q[5];
			2'd1: taken = p_q[c6502_pkg::FB_V] == op_q[5];
			2'd2: taken = p_q[c6502_pkg::FB_C] == op_q[5];
			default: taken = p_q[c6502_pkg::FB_Z] == op_q[5];
		endcase
		alu_a = reg_sel(dec.rsel, a_q, x_q, y_q, s_q, p_q);
		alu_b = (state_q == c6502_pkg::S_RD || state_q == c6502_pkg::S_PL) ? rdata : alu_a;
	end

	c6502_alu u_alu (
		.op        (dec.aop),
		.a         (alu_a),
		.b         (alu_b),
		.flags_in  (p_q),
		.res       (alu_res),
		.flags_out (alu_flags)
	);

	c6502_ram u_ram (
		.clk     (clk),
		.we      (mem_we),
		.addr    (mem_a16[AW-1:0]),
		.wdata   (mem_wd),
		.rdata_q (rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			c6502_pkg::S_CLR: if (clr_q == {AW{1'b1}}) state_d = c6502_pkg::S_IDLE;
			c6502_pkg::S_IDLE: begin
				if (in_acc) begin
					case (kind)
						c6502_pkg::KIND_STEP:
							state_d = halt_q ? c6502_pkg::S_DONE : c6502_pkg::S_FETCH;
						c6502_pkg::KIND_IRQ:
							state_d = (halt_q || p_q[c6502_pkg::FB_I]) ?
								c6502_pkg::S_DONE : c6502_pkg::S_IRQ1;
						c6502_pkg::KIND_RESET: state_d = c6502_pkg::S_RESET;
						c6502_pkg::KIND_WRITE: state_d = c6502_pkg::S_MWR;
						c6502_pkg::KIND_READ:  state_d = c6502_pkg::S_MRD;
						default: state_d = c6502_pkg::S_DONE;
					endcase
				end
			end
			c6502_pkg::S_FETCH: state_d = c6502_pkg::S_DEC;
			c6502_pkg::S_DEC:   state_d = c6502_pkg::S_DISP;
			c6502_pkg::S_DISP: begin
				case (dec.cls)
					c6502_pkg::CL_BRANCH: state_d = c6502_pkg::S_BR;
					c6502_pkg::CL_PULL:   state_d = c6502_pkg::S_PL;
					c6502_pkg::CL_RTS:    state_d = c6502_pkg::S_P2;
					c6502_pkg::CL_RTI:    state_d = c6502_pkg::S_P1;
					c6502_pkg::CL_JMP, c6502_pkg::CL_JMPI, c6502_pkg::CL_JSR,
					c6502_pkg::CL_READ, c6502_pkg::CL_STORE, c6502_pkg::CL_RMW:
						state_d = (dec.mode == c6502_pkg::AM_IMM) ?
							c6502_pkg::S_OPER : c6502_pkg::S_A2;
					default: state_d = c6502_pkg::S_DONE;
				endcase
			end
			c6502_pkg::S_A2: begin
				case (dec.mode)
					c6502_pkg::AM_ABS, c6502_pkg::AM_ABSX, c6502_pkg::AM_ABSY:
						state_d = c6502_pkg::S_A3;
					c6502_pkg::AM_INDX, c6502_pkg::AM_INDY: state_d = c6502_pkg::S_I1;
					default: state_d = c6502_pkg::S_OPER;
				endcase
			end
			c6502_pkg::S_A3: state_d = c6502_pkg::S_OPER;
			c6502_pkg::S_I1: state_d = c6502_pkg::S_I2;
			c6502_pkg::S_I2: state_d = c6502_pkg::S_OPER;
			c6502_pkg::S_OPER: begin
				case (dec.cls)
					c6502_pkg::CL_READ, c6502_pkg::CL_RMW: state_d = c6502_pkg::S_RD;
					c6502_pkg::CL_JMPI: state_d = c6502_pkg::S_JI1;
					c6502_pkg::CL_JSR:  state_d = c6502_pkg::S_JS2;
					default: state_d = c6502_pkg::S_DONE;
				endcase
			end
			c6502_pkg::S_JI1:  state_d = c6502_pkg::S_JI2;
			c6502_pkg::S_P1:   state_d = c6502_pkg::S_P2;
			c6502_pkg::S_P2:   state_d = c6502_pkg::S_P3;
			c6502_pkg::S_IRQ1: state_d = c6502_pkg::S_IRQ2;
			c6502_pkg::S_IRQ2: state_d = c6502_pkg::S_IRQ3;
			c6502_pkg::S_IRQ3: state_d = c6502_pkg::S_IRQ4;
			c6502_pkg::S_IRQ4: state_d = c6502_pkg::S_IRQ5;
			c6502_pkg::S_IRQ5: state_d = c6502_pkg::S_IRQ6;
			c6502_pkg::S_MRD:  state_d = c6502_pkg::S_MRD2;
			c6502_pkg::S_DONE: if (out_load) state_d = c6502_pkg::S_IDLE;
			default: state_d = c6502_pkg::S_DONE;
		endcase
	end

	// Memory port and handshake outputs.
	always_comb begin
		in_stall = (state_q != c6502_pkg::S_IDLE);
		mem_a16 = pc_q;
		mem_we = 1'b0;
		mem_wd = 8'h00;
		case (state_q)
			c6502_pkg::S_CLR: begin
				mem_a16 = 16'(clr_q);
				mem_we = 1'b1;
			end
			c6502_pkg::S_DISP: begin
				case (dec.cls)
					c6502_pkg::CL_PUSH: begin
						mem_a16 = {c6502_pkg::STACK_PAGE, s_q};
						mem_we = 1'b1;
						mem_wd = alu_a;
					end
					c6502_pkg::CL_PULL, c6502_pkg::CL_RTS, c6502_pkg::CL_RTI:
						mem_a16 = {c6502_pkg::STACK_PAGE, s_q + 8'd1};
					default: mem_a16 = pc_q;
				endcase
			end
			c6502_pkg::S_A2: begin
				if (dec.mode == c6502_pkg::AM_INDX || dec.mode == c6502_pkg::AM_INDY)
					mem_a16 = {8'h00, zp};
			end
			c6502_pkg::S_I1: mem_a16 = {8'h00, ea_q[7:0] + 8'd1};
			c6502_pkg::S_OPER: begin
				mem_a16 = ea_q;
				if (dec.cls == c6502_pkg::CL_STORE) begin
					mem_we = 1'b1;
					mem_wd = alu_a;
				end else if (dec.cls == c6502_pkg::CL_JSR) begin
					mem_a16 = {c6502_pkg::STACK_PAGE, s_q};
					mem_we = 1'b1;
					mem_wd = pcm1[15:8];
				end
			end
			c6502_pkg::S_RD: begin
				mem_a16 = ea_q;
				mem_we = (dec.dst == c6502_pkg::D_MEM);
				mem_wd = alu_res;
			end
			c6502_pkg::S_JI1: mem_a16 = ea_q + 16'd1;
			c6502_pkg::S_JS2: begin
				mem_a16 = {c6502_pkg::STACK_PAGE, s_q};
				mem_we = 1'b1;
				mem_wd = pcm1[7:0];
			end
			c6502_pkg::S_P1, c6502_pkg::S_P2:
				mem_a16 = {c6502_pkg::STACK_PAGE, s_q + 8'd1};
			c6502_pkg::S_IRQ1: begin
				mem_a16 = {c6502_pkg::STACK_PAGE, s_q};
				mem_we = 1'b1;
				mem_wd = pc_q[15:8];
			end
			c6502_pkg::S_IRQ2: begin
				mem_a16 = {c6502_pkg::STACK_PAGE, s_q};
				mem_we = 1'b1;
				mem_wd = pc_q[7:0];
			end
			c6502_pkg::S_IRQ3: begin
				mem_a16 = {c6502_pkg::STACK_PAGE, s_q};
				mem_we = 1'b1;
				mem_wd = (p_q & ~8'h10) | 8'h20;
			end
			c6502_pkg::S_IRQ4: mem_a16 = c6502_pkg::IRQ_VEC_LO;
			c6502_pkg::S_IRQ5: mem_a16 = c6502_pkg::IRQ_VEC_HI;
			c6502_pkg::S_MWR: begin
				mem_a16 = addr_q;
				mem_we = 1'b1;
				mem_wd = wdata_q;
			end
			c6502_pkg::S_MRD: mem_a16 = addr_q;
			default: mem_a16 = pc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c6502_pkg::S_CLR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == c6502_pkg::S_CLR) clr_q <= clr_q + 1'b1;
		end
	end

	// Architectural registers, updated by the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 8'h00;
			x_q <= 8'h00;
			y_q <= 8'h00;
			s_q <= c6502_pkg::SP_RESET;
			p_q <= c6502_pkg::FLAGS_RESET;
			pc_q <= 16'h0000;
			cyc_q <= 32'h0;
			halt_q <= 1'b0;
			rv_q <= 8'h00;
		end else begin
			case (state_q)
				c6502_pkg::S_IDLE: if (in_acc) rv_q <= 8'h00;
				c6502_pkg::S_RESET: begin
					a_q <= 8'h00;
					x_q <= 8'h00;
					y_q <= 8'h00;
					s_q <= c6502_pkg::SP_RESET;
					p_q <= c6502_pkg::FLAGS_RESET;
					pc_q <= addr_q;
					cyc_q <= 32'h0;
					halt_q <= 1'b0;
				end
				c6502_pkg::S_FETCH: pc_q <= pc_q + 16'd1;
				c6502_pkg::S_DISP: begin
					cyc_q <= cyc_q + {29'h0, dec.cyc};
					case (dec.cls)
						c6502_pkg::CL_BAD, c6502_pkg::CL_BRK: halt_q <= 1'b1;
						c6502_pkg::CL_IMPL: begin
							case (dec.dst)
								c6502_pkg::D_A: a_q <= alu_res;
								c6502_pkg::D_X: x_q <= alu_res;
								c6502_pkg::D_Y: y_q <= alu_res;
								c6502_pkg::D_S: s_q <= alu_res;
								default: ;
							endcase
							p_q <= (alu_flags & ~dec.fmask) | (dec.fval & dec.fmask);
						end
						c6502_pkg::CL_PUSH: s_q <= s_q - 8'd1;
						c6502_pkg::CL_PULL, c6502_pkg::CL_RTS, c6502_pkg::CL_RTI:
							s_q <= s_q + 8'd1;
						default: pc_q <= pc_q + 16'd1;
					endcase
				end
				c6502_pkg::S_A2: begin
					if (dec.mode == c6502_pkg::AM_ABS || dec.mode == c6502_pkg::AM_ABSX ||
						dec.mode == c6502_pkg::AM_ABSY)
						pc_q <= pc_q + 16'd1;
				end
				c6502_pkg::S_OPER: begin
					if (dec.cls == c6502_pkg::CL_JMP) pc_q <= ea_q;
					if (dec.cls == c6502_pkg::CL_JSR) s_q <= s_q - 8'd1;
				end
				c6502_pkg::S_RD: begin
					case (dec.dst)
						c6502_pkg::D_A: a_q <= alu_res;
						c6502_pkg::D_X: x_q <= alu_res;
						c6502_pkg::D_Y: y_q <= alu_res;
						default: ;
					endcase
					p_q <= alu_flags;
				end
				c6502_pkg::S_JI2: pc_q <= {rdata, tmp_q};
				c6502_pkg::S_JS2: begin
					s_q <= s_q - 8'd1;
					pc_q <= ea_q;
				end
				c6502_pkg::S_BR: begin
					if (taken) begin
						pc_q <= pc_q + {{8{rdata[7]}}, rdata};
						cyc_q <= cyc_q + 32'd1;
					end
				end
				c6502_pkg::S_PL: begin
					if (dec.dst == c6502_pkg::D_P) begin
						p_q <= (rdata & ~8'h10) | 8'h20;
					end else begin
						a_q <= alu_res;
						p_q <= alu_flags;
					end
				end
				c6502_pkg::S_P1: begin
					p_q <= (rdata & ~8'h10) | 8'h20;
					s_q <= s_q + 8'd1;
				end
				c6502_pkg::S_P2: s_q <= s_q + 8'd1;
				c6502_pkg::S_P3: pc_q <= {rdata, tmp_q} +
					{15'h0, (op_q == c6502_pkg::OPC_RTS)};
				c6502_pkg::S_IRQ1: begin
					s_q <= s_q - 8'd1;
					cyc_q <= cyc_q + 32'd7;
				end
				c6502_pkg::S_IRQ2: s_q <= s_q - 8'd1;
				c6502_pkg::S_IRQ3: begin
					s_q <= s_q - 8'd1;
					p_q[c6502_pkg::FB_I] <= 1'b1;
				end
				c6502_pkg::S_IRQ6: pc_q <= {rdata, tmp_q};
				c6502_pkg::S_MRD2: rv_q <= rdata;
				default: ;
			endcase
		end
	end

	// Instruction and address scratch registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind;
			addr_q <= address;
			wdata_q <= write_data;
		end
		case (state_q)
			c6502_pkg::S_DEC: op_q <= rdata;
			c6502_pkg::S_DISP: ea_q <= pc_q;
			c6502_pkg::S_A2: begin
				tmp_q <= rdata;
				ea_q <= {8'h00, zp};
			end
			c6502_pkg::S_A3, c6502_pkg::S_I2: ea_q <= ea_abs;
			c6502_pkg::S_I1, c6502_pkg::S_JI1, c6502_pkg::S_P2, c6502_pkg::S_IRQ5:
				tmp_q <= rdata;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			acc_value <= a_q;
			x_value <= x_q;
			y_value <= y_q;
			stack_pointer <= s_q;
			program_counter <= pc_q;
			status_flags <= p_q;
			cycle_count <= cyc_q;
			is_halted <= halt_q;
			read_value <= (kind_q == c6502_pkg::KIND_READ) ? rv_q : 8'h00;
		end
	end

	`ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_acc, state_q != c6502_pkg::S_IDLE)
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, halt_q && state_q != c6502_pkg::S_RESET, halt_q)
	`ASSERT_ALWAYS(a_no_idle_write, clk, arst_n, !(state_q == c6502_pkg::S_IDLE && mem_we))

endmodule
`default_nettype wire

### rtl/c6502_ram.sv
// ----------------------------------------------------------------------------
// c6502_ram
// Single-port byte memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module c6502_ram (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [c6502_pkg::MEM_ADDR_BITS-1:0] addr,
	input  wire logic [7:0]                          wdata,
	output logic      [7:0]                          rdata_q
);

	logic [7:0] mem [0:c6502_pkg::MEM_DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

endmodule
`default_nettype wire

### rtl/c6502_alu.sv
// ----------------------------------------------------------------------------
// c6502_alu
// Shared arithmetic, logic, compare and shift unit with flag update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module c6502_alu (
	input  wire c6502_pkg::alu_op_t op,
	input  wire logic [7:0]         a,
	input  wire logic [7:0]         b,
	input  wire logic [7:0]         flags_in,
	output logic      [7:0]         res,
	output logic      [7:0]         flags_out
);

	logic [7:0] bb;
	logic [8:0] sum;
	logic [8:0] diff;
	logic       upd_zn;

	always_comb begin
		bb = (op == c6502_pkg::OP_SBC) ? ~b : b;
		sum = {1'b0, a} + {1'b0, bb} + {8'h00, flags_in[c6502_pkg::FB_C]};
		diff = {1'b0, a} - {1'b0, b};
		res = b;
		flags_out = flags_in;
		upd_zn = 1'b1;
		case (op)
			c6502_pkg::OP_OR:  res = a | b;
			c6502_pkg::OP_AND: res = a & b;
			c6502_pkg::OP_EOR: res = a ^ b;
			c6502_pkg::OP_LD:  res = b;
			c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
				res = sum[7:0];
				flags_out[c6502_pkg::FB_C] = sum[8];
				flags_out[c6502_pkg::FB_V] = (a[7] ^ sum[7]) & (bb[7] ^ sum[7]);
			end
			c6502_pkg::OP_CMP: begin
				res = diff[7:0];
				flags_out[c6502_pkg::FB_C] = ~diff[8];
			end
			c6502_pkg::OP_BIT: begin
				upd_zn = 1'b0;
				flags_out[c6502_pkg::FB_Z] = ((a & b) == 8'h00);
				flags_out[c6502_pkg::FB_V] = b[6];
				flags_out[c6502_pkg::FB_N] = b[7];
			end
			c6502_pkg::OP_ASL: begin
				res = {b[6:0], 1'b0};
				flags_out[c6502_pkg::FB_C] = b[7];
			end
			c6502_pkg::OP_ROL: begin
				res = {b[6:0], flags_in[c6502_pkg::FB_C]};
				flags_out[c6502_pkg::FB_C] = b[7];
			end
			c6502_pkg::OP_LSR: begin
				res = {1'b0, b[7:1]};
				flags_out[c6502_pkg::FB_C] = b[0];
			end
			c6502_pkg::OP_ROR: begin
				res = {flags_in[c6502_pkg::FB_C], b[7:1]};
				flags_out[c6502_pkg::FB_C] = b[0];
			end
			c6502_pkg::OP_INC: res = b + 8'd1;
			c6502_pkg::OP_DEC: res = b - 8'd1;
			default: upd_zn = 1'b0;
		endcase
		if (upd_zn) begin
			flags_out[c6502_pkg::FB_Z] = (res == 8'h00);
			flags_out[c6502_pkg::FB_N] = res[7];
		end
	end

endmodule
`default_nettype wire

### bench/cpu_8bit_6502_core_top_tb.sv
// ----------------------------------------------------------------------------
// cpu_8bit_6502_core_top_tb
// Drives instruction steps, interrupt requests, register resets, memory words and
// undefined kinds into the core, predicts the register state after every word with
// a behavioural copy of the processor, and checks each result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class cpu_scoreboard;
	logic [7:0]  a, x, y, sp, p, halt;
	logic [15:0] pc;
	logic [31:0] cyc;
	logic [7:0]  mem [0:65535];
	logic [96:0] pending [$];
	int          errors;

	function new();
		errors = 0;
		hard_reset();
	endfunction

	function void hard_reset();
		for (int i = 0; i < 65536; i++) mem[i] = 8'h00;
		regs_reset(16'h0000);
	endfunction

	function void regs_reset(logic [15:0] start);
		a = 0; x = 0; y = 0; sp = c6502_pkg::SP_RESET; pc = start;
		p = c6502_pkg::FLAGS_RESET; cyc = 0; halt = 0;
	endfunction

	function logic [7:0] fetch8();
		logic [7:0] v;
		v = mem[pc];
		pc = pc + 16'd1;
		return v;
	endfunction

	function logic [15:0] fetch16();
		logic [7:0] lo;
		lo = fetch8();
		return {fetch8(), lo};
	endfunction

	function void push8(logic [7:0] v);
		mem[{8'h01, sp}] = v;
		sp = sp - 8'd1;
	endfunction

	function logic [7:0] pop8();
		sp = sp + 8'd1;
		return mem[{8'h01, sp}];
	endfunction

	function void zn(logic [7:0] v);
		p[c6502_pkg::FB_Z] = (v == 0);
		p[c6502_pkg::FB_N] = v[7];
	endfunction

	function logic [15:0] ea(c6502_pkg::am_t m);
		logic [7:0]  z;
		logic [15:0] t;
		case (m)
			c6502_pkg::AM_IMM: begin
				t = pc; pc = pc + 16'd1; return t;
			end
			c6502_pkg::AM_ZP: return {8'h00, fetch8()};
			c6502_pkg::AM_ZPX: begin
				z = fetch8() + x; return {8'h00, z};
			end
			c6502_pkg::AM_ZPY: begin
				z = fetch8() + y; return {8'h00, z};
			end
			c6502_pkg::AM_ABS: return fetch16();
			c6502_pkg::AM_ABSX: return fetch16() + {8'h00, x};
			c6502_pkg::AM_ABSY: return fetch16() + {8'h00, y};
			c6502_pkg::AM_INDX: begin
				z = fetch8() + x;
				return {mem[{8'h00, z + 8'd1}], mem[{8'h00, z}]};
			end
			default: begin
				z = fetch8();
				t = {mem[{8'h00, z + 8'd1}], mem[{8'h00, z}]};
				return t + {8'h00, y};
			end
		endcase
	endfunction

	function void add_carry(logic [7:0] v);
		logic [8:0] s;
		s = a + v + p[0];
		p[c6502_pkg::FB_C] = s[8];
		p[c6502_pkg::FB_V] = (a[7] ^ s[7]) & (v[7] ^ s[7]);
		a = s[7:0];
		zn(a);
	endfunction

	function void compare(logic [7:0] r, logic [7:0] v);
		p[c6502_pkg::FB_C] = (r >= v);
		zn(r - v);
	endfunction

	function logic [7:0] shift(logic [2:0] k, logic [7:0] v);
		logic [7:0] r;
		if (k <= 1) begin
			r = {v[6:0], k == 1 ? p[0] : 1'b0};
			p[0] = v[7];
		end else begin
			r = {k == 3 ? p[0] : 1'b0, v[7:1]};
			p[0] = v[0];
		end
		zn(r);
		return r;
	endfunction

	function void exec_group(logic [7:0] op);
		logic [2:0] aaa, bbb;
		logic [1:0] cc;
		logic [7:0] vm, v;
		logic [15:0] ad;
		c6502_pkg::am_t m;
		logic acc_mode;
		aaa = op[7:5]; bbb = op[4:2]; cc = op[1:0];
		if (cc == 1) begin
			if (aaa == 4 && bbb == 2) begin
				halt = 1; return;
			end
			ad = ea(c6502_pkg::ALU_MODE[bbb]);
			cyc += (aaa == 4) ? c6502_pkg::STA_CYC[bbb] : c6502_pkg::ALU_CYC[bbb];
			if (aaa == 4) begin
				mem[ad] = a; return;
			end
			v = mem[ad];
			case (aaa)
				0: begin a = a | v; zn(a); end
				1: begin a = a & v; zn(a); end
				2: begin a = a ^ v; zn(a); end
				3: add_carry(v);
				5: begin a = v; zn(a); end
				6: compare(a, v);
				default: add_carry(~v);
			endcase
			return;
		end
		if (cc == 0)
			vm = aaa == 1 ? 8'h0A : aaa == 4 ? 8'h2A : aaa == 5 ? 8'hAB : aaa >= 6 ? 8'h0B : 8'h00;
		else if (cc == 2)
			vm = aaa <= 3 ? 8'hAE : aaa == 4 ? 8'h2A : aaa == 5 ? 8'hAB : 8'hAA;
		else
			vm = 0;
		if (!vm[bbb]) begin
			halt = 1; return;
		end
		// Index X becomes Y for the X register loads and stores.
		acc_mode = (bbb == 2 && cc == 2);
		m = c6502_pkg::GRP_MODE[bbb];
		if (cc == 2 && (aaa == 4 || aaa == 5)) begin
			if (m == c6502_pkg::AM_ZPX) m = c6502_pkg::AM_ZPY;
			if (m == c6502_pkg::AM_ABSX) m = c6502_pkg::AM_ABSY;
		end
		cyc += (cc == 2 && aaa != 4 && aaa != 5) ? c6502_pkg::RMW_CYC[bbb] : c6502_pkg::LD_CYC[bbb];
		if (acc_mode) begin
			a = shift(aaa, a); return;
		end
		ad = ea(m);
		if (cc == 0) begin
			case (aaa)
				1: begin
					v = mem[ad];
					p[c6502_pkg::FB_Z] = ((a & v) == 0);
					p[c6502_pkg::FB_V] = v[6];
					p[c6502_pkg::FB_N] = v[7];
				end
				4: mem[ad] = y;
				5: begin y = mem[ad]; zn(y); end
				6: compare(y, mem[ad]);
				default: compare(x, mem[ad]);
			endcase
			return;
		end
		case (aaa)
			4: mem[ad] = x;
			5: begin x = mem[ad]; zn(x); end
			6: begin v = mem[ad] - 8'd1; mem[ad] = v; zn(v); end
			7: begin v = mem[ad] + 8'd1; mem[ad] = v; zn(v); end
			default: mem[ad] = shift(aaa, mem[ad]);
		endcase
	endfunction

	function void exec_step();
		logic [7:0]  op, off, m, lo;
		logic [15:0] t, tgt;
		if (halt) return;
		op = fetch8();
		if (op[4:0] == 5'h10) begin
			m = op[7:6] == 0 ? 8'h80 : op[7:6] == 1 ? 8'h40 : op[7:6] == 2 ? 8'h01 : 8'h02;
			off = fetch8();
			cyc += 2;
			if (((p & m) != 0) == op[5]) begin
				pc = pc + {{8{off[7]}}, off};
				cyc += 1;
			end
			return;
		end
		case (op)
			8'h00: begin halt = 1; cyc += 7; end
			8'hEA: cyc += 2;
			8'h18: begin p[0] = 0; cyc += 2; end
			8'h38: begin p[0] = 1; cyc += 2; end
			8'h58: begin p[2] = 0; cyc += 2; end
			8'h78: begin p[2] = 1; cyc += 2; end
			8'hB8: begin p[6] = 0; cyc += 2; end
			8'hD8: begin p[3] = 0; cyc += 2; end
			8'hF8: begin p[3] = 1; cyc += 2; end
			8'hAA: begin x = a; zn(x); cyc += 2; end
			8'h8A: begin a = x; zn(a); cyc += 2; end
			8'hA8: begin y = a; zn(y); cyc += 2; end
			8'h98: begin a = y; zn(a); cyc += 2; end
			8'h9A: begin sp = x; cyc += 2; end
			8'hBA: begin x = sp; zn(x); cyc += 2; end
			8'hE8: begin x = x + 1; zn(x); cyc += 2; end
			8'hC8: begin y = y + 1; zn(y); cyc += 2; end
			8'hCA: begin x = x - 1; zn(x); cyc += 2; end
			8'h88: begin y = y - 1; zn(y); cyc += 2; end
			8'h48: begin push8(a); cyc += 3; end
			8'h68: begin a = pop8(); zn(a); cyc += 4; end
			8'h08: begin push8(p | 8'h30); cyc += 3; end
			8'h28: begin p = (pop8() & 8'hEF) | 8'h20; cyc += 4; end
			8'h4C: begin pc = fetch16(); cyc += 3; end
			8'h6C: begin
				t = fetch16();
				pc = {mem[t + 16'd1], mem[t]};
				cyc += 5;
			end
			8'h20: begin
				tgt = fetch16();
				t = pc - 16'd1;
				push8(t[15:8]); push8(t[7:0]);
				pc = tgt; cyc += 6;
			end
			8'h60: begin
				lo = pop8();
				pc = {pop8(), lo} + 16'd1;
				cyc += 6;
			end
			8'h40: begin
				p = (pop8() & 8'hEF) | 8'h20;
				lo = pop8();
				pc = {pop8(), lo};
				cyc += 6;
			end
			default: exec_group(op);
		endcase
	endfunction

	function void note_word(logic [2:0] k, logic [15:0] ad, logic [7:0] wd);
		logic [7:0] rv;
		rv = 0;
		case (k)
			c6502_pkg::KIND_STEP: exec_step();
			c6502_pkg::KIND_IRQ: begin
				if (!p[c6502_pkg::FB_I] && !halt) begin
					push8(pc[15:8]); push8(pc[7:0]);
					push8((p & 8'hEF) | 8'h20);
					p[c6502_pkg::FB_I] = 1;
					pc = {mem[c6502_pkg::IRQ_VEC_HI], mem[c6502_pkg::IRQ_VEC_LO]};
					cyc += 7;
				end
			end
			c6502_pkg::KIND_RESET: regs_reset(ad);
			c6502_pkg::KIND_WRITE: mem[ad] = wd;
			c6502_pkg::KIND_READ: rv = mem[ad];
			default: ;
		endcase
		pending.push_back({a, x, y, sp, pc, p, cyc, halt[0], rv});
	endfunction

	function void check_word(logic [96:0] got);
		logic [96:0] e;
		if (pending.size() == 0) begin
			$display("%0t: result word with nothing expected, actual %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e !== got) begin
			$display("%0t: mismatch expected a=%h x=%h y=%h sp=%h pc=%h p=%h cyc=%h h=%b rv=%h",
				$time, e[96:89], e[88:81], e[80:73], e[72:65], e[64:49], e[48:41],
				e[40:9], e[8], e[7:0]);
			$display("%0t:          actual a=%h x=%h y=%h sp=%h pc=%h p=%h cyc=%h h=%b rv=%h",
				$time, got[96:89], got[88:81], got[80:73], got[72:65], got[64:49],
				got[48:41], got[40:9], got[8], got[7:0]);
			errors++;
		end
	endfunction
endclass

module cpu_8bit_6502_core_top_tb;

	logic        clk, arst_n, in_valid, in_stall, out_valid, out_stall;
	logic [2:0]  kind;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [7:0]  acc_value, x_value, y_value, stack_pointer, status_flags, read_value;
	logic [15:0] program_counter;
	logic [31:0] cycle_count;
	logic        is_halted;

	cpu_scoreboard cpu_model;
	int idle_cycles;

	cpu_8bit_6502_core_top dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Valid stays high from one word to the next when there is no gap.
	task automatic send_word(logic [2:0] k, logic [15:0] ad, logic [7:0] wd);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; kind <= k; address <= ad; write_data <= wd;
		do @(posedge clk); while (in_stall);
		cpu_model.note_word(k, ad, wd);
	endtask

	task automatic poke(logic [15:0] ad, logic [7:0] v);
		send_word(c6502_pkg::KIND_WRITE, ad, v);
	endtask

	task automatic step();
		send_word(c6502_pkg::KIND_STEP, 16'($urandom), 8'($urandom));
	endtask

	// Opcode byte with its two operand bytes at the program counter.
	task automatic place_insn(logic [7:0] op);
		logic [15:0] pc;
		pc = cpu_model.pc;
		poke(pc, op);
		poke(pc + 16'd1, 8'($urandom));
		poke(pc + 16'd2, 8'($urandom));
	endtask

	task automatic restart();
		send_word(c6502_pkg::KIND_RESET,
			$urandom_range(0, 3) == 0 ? 16'hFFFE : 16'($urandom), 8'($urandom));
	endtask

	// Receiver side: random stall per word, result checked at acceptance.
	initial begin
		int w;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w != 0) begin
				out_stall <= 1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			cpu_model.check_word({acc_value, x_value, y_value, stack_pointer,
				program_counter, status_flags, cycle_count, is_halted, read_value});
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("FAIL cpu_8bit_6502_core_top");
			$finish;
		end
	end

	initial begin
		logic [7:0] op;
		logic [7:0] dir_ops [0:15];
		dir_ops = '{8'hA9, 8'h69, 8'hE9, 8'h6C, 8'h20, 8'h60, 8'h48,
			8'h08, 8'h28, 8'h40, 8'h0A, 8'h6A, 8'h00, 8'h02, 8'hD0, 8'h58};
		cpu_model = new();
		idle_cycles = 0;
		in_valid = 0; kind = 0; address = 0; write_data = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: memory extremes, vector, interrupt paths and opcode set.
		poke(16'h0000, 8'hFF);
		poke(16'hFFFF, 8'h12);
		poke(16'hFFFE, 8'h34);
		send_word(c6502_pkg::KIND_READ, 16'hFFFF, 8'h00);
		send_word(c6502_pkg::KIND_READ, 16'h0000, 8'h00);
		send_word(c6502_pkg::KIND_IRQ, 16'h0000, 8'h00);
		send_word(c6502_pkg::KIND_RESET, 16'h10FF, 8'h00);
		send_word(c6502_pkg::KIND_STEP, 16'h0000, 8'h00);
		for (int i = 0; i < 16; i++) begin
			restart();
			place_insn(dir_ops[i]);
			step();
			step();
		end
		// JMP indirect whose pointer crosses a page boundary.
		send_word(c6502_pkg::KIND_RESET, 16'h0300, 8'h00);
		poke(16'h0300, 8'h6C); poke(16'h0301, 8'hFF); poke(16'h0302, 8'h02);
		poke(16'h02FF, 8'hAB); poke(16'h0300 + 16'd0, 8'h6C);
		step();
		send_word(3'd5, 16'hFFFF, 8'hFF);
		send_word(3'd7, 16'h0000, 8'h00);

		// Random programs: mostly well-formed instructions, some noise.
		for (int n = 0; n < 320; n++) begin
			if ($urandom_range(0, 9) == 0) restart();
			if ($urandom_range(0, 7) == 0) begin
				send_word(c6502_pkg::KIND_IRQ, 16'($urandom), 8'($urandom));
			end else if ($urandom_range(0, 7) == 0) begin
				send_word(3'($urandom_range(3, 7)), 16'($urandom), 8'($urandom));
			end else begin
				op = 8'($urandom);
				if ($urandom_range(0, 5) != 0)
					while (op == 8'h00 || op[1:0] == 2'd3) op = 8'($urandom);
				if ($urandom_range(0, 3) == 0) op = 8'h58;
				place_insn(op);
				step();
			end
		end
		in_valid <= 0;
		while (cpu_model.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (cpu_model.errors == 0)
			$display("PASS cpu_8bit_6502_core_top");
		else
			$display("FAIL cpu_8bit_6502_core_top");
		$finish;
	end
endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/c6502_pkg.sv
rtl/c6502_ram.sv
rtl/c6502_alu.sv
rtl/cpu_8bit_6502_core_top.sv
bench/cpu_8bit_6502_core_top_tb.sv
